### design/led_matrix_bitplane_scanner_core_macros.svh
// assertion macros for the led matrix bit-plane scanner
`ifndef LED_MATRIX_BITPLANE_SCANNER_CORE_MACROS_SVH
`define LED_MATRIX_BITPLANE_SCANNER_CORE_MACROS_SVH

// same-cycle implication, reset masks the check
`define LMBS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masks the check
`define LMBS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lmbs_pkg.sv
// constants and helpers for the led matrix bit-plane scanner
`default_nettype none

package lmbs_pkg;

    localparam int DEFAULT_PANEL_WIDTH   = 128;
    localparam int DEFAULT_ROW_ADDR_BITS = 4;
    localparam int DEFAULT_PLANES        = 8;

    localparam int STORE_DEPTH  = 4096;
    localparam int ADDR_W       = 12;
    localparam int PIXEL_W      = 24;
    localparam int BASE_W       = 16;
    localparam int ON_TIME_W    = 23;
    localparam int PLANE_W      = 3;
    localparam int COLUMN_W     = 8;
    localparam int ROW_OUT_W    = 4;
    localparam int BITS_W       = 3;

    localparam logic [BASE_W-1:0] ON_TIME_BASE_RESET = 16'd50;

    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_TICK  = 1'b1;

    // pick one plane bit out of each colour byte: bit0 red, bit1 green, bit2 blue
    function automatic logic [BITS_W-1:0] plane_bits(input logic [PIXEL_W-1:0] pixel,
                                                     input logic [PLANE_W-1:0] plane);
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        red   = pixel[7:0];
        green = pixel[15:8];
        blue  = pixel[23:16];
        return {blue[plane], green[plane], red[plane]};
    endfunction

endpackage

`default_nettype wire

### design/led_matrix_bitplane_scanner_core.sv
// top level of the led matrix bit-plane scanner: frame store, scan counters, output stage
// path: an accepted tick word is registered in the store read stage, then in the output register
// throughput: one word per cycle unless out_ready stalls, set by the two-port frame store read and the output register
// pixel writes produce no output word and take effect for a tick in the very next cycle
// reset: counters, valids and on_time_base (50) clear at once; the frame store is not cleared
`default_nettype none

`include "led_matrix_bitplane_scanner_core_macros.svh"

module led_matrix_bitplane_scanner_core #(
    parameter int PANEL_WIDTH   = lmbs_pkg::DEFAULT_PANEL_WIDTH,
    parameter int ROW_ADDR_BITS = lmbs_pkg::DEFAULT_ROW_ADDR_BITS,
    parameter int PLANES        = lmbs_pkg::DEFAULT_PLANES
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    // configuration write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [lmbs_pkg::BASE_W-1:0]       cfg_data,

    // input words
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire logic [lmbs_pkg::ADDR_W-1:0]       pixel_addr,
    input  wire logic [lmbs_pkg::PIXEL_W-1:0]      pixel_rgb,

    // output words
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   is_latch,
    output logic [lmbs_pkg::BITS_W-1:0]            upper_bits,
    output logic [lmbs_pkg::BITS_W-1:0]            lower_bits,
    output logic [lmbs_pkg::COLUMN_W-1:0]          column,
    output logic [lmbs_pkg::ROW_OUT_W-1:0]         row_addr,
    output logic [lmbs_pkg::PLANE_W-1:0]           bit_plane,
    output logic [lmbs_pkg::ON_TIME_W-1:0]         on_time,
    output logic                                   frame_done
);

    // column counter has to hold the dummy step and the latch step past the last column
    localparam int COL_W     = $clog2(PANEL_WIDTH + 2);
    localparam int ROW_PAIRS = 1 << ROW_ADDR_BITS;

    localparam logic [COL_W-1:0]         COL_DUMMY  = COL_W'(PANEL_WIDTH);
    localparam logic [ROW_ADDR_BITS-1:0] ROW_LAST   = ROW_ADDR_BITS'(ROW_PAIRS - 1);
    localparam logic [lmbs_pkg::PLANE_W-1:0] PLANE_LAST = lmbs_pkg::PLANE_W'(PLANES - 1);

    // ------------------------------------------------------------------
    // configuration register, always ready
    // ------------------------------------------------------------------
    logic [lmbs_pkg::BASE_W-1:0] on_time_base_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_time_base_reg <= lmbs_pkg::ON_TIME_BASE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            on_time_base_reg <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // flow control across the two stages
    // ------------------------------------------------------------------
    logic s1_valid_reg;
    logic s1_valid_next;
    logic out_valid_reg;
    logic out_valid_next;
    logic s2_free;
    logic s1_free;
    logic accept;
    logic tick;
    logic wr_en;

    // output register frees when empty or taken; the read stage frees when it can move on
    assign s2_free  = !out_valid_reg || out_ready;
    assign s1_free  = !s1_valid_reg || s2_free;
    assign in_ready = s1_free;
    assign accept   = in_valid && in_ready;
    assign tick     = accept && (req_type == lmbs_pkg::REQ_TICK);
    assign wr_en    = accept && (req_type == lmbs_pkg::REQ_WRITE);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (s1_free)
        begin
            s1_valid_next = tick;
        end
        out_valid_next = out_valid_reg;
        if (s2_free)
        begin
            out_valid_next = s1_valid_reg;
        end
    end

    // ------------------------------------------------------------------
    // scan counters: columns innermost, then planes, then row pairs
    // ------------------------------------------------------------------
    logic [COL_W-1:0]                 col_count_reg;
    logic [COL_W-1:0]                 col_count_next;
    logic [lmbs_pkg::PLANE_W-1:0]     plane_count_reg;
    logic [lmbs_pkg::PLANE_W-1:0]     plane_count_next;
    logic [ROW_ADDR_BITS-1:0]         row_count_reg;
    logic [ROW_ADDR_BITS-1:0]         row_count_next;

    logic step_data;
    logic step_latch;
    logic last_step;

    assign step_data  = col_count_reg < COL_DUMMY;
    assign step_latch = col_count_reg > COL_DUMMY;
    assign last_step  = (plane_count_reg == PLANE_LAST) && (row_count_reg == ROW_LAST);

    always_comb
    begin
        col_count_next   = col_count_reg;
        plane_count_next = plane_count_reg;
        row_count_next   = row_count_reg;
        if (tick)
        begin
            if (step_latch)
            begin
                col_count_next = '0;
                if (plane_count_reg == PLANE_LAST)
                begin
                    plane_count_next = '0;
                    if (row_count_reg == ROW_LAST)
                    begin
                        row_count_next = '0;
                    end
                    else
                    begin
                        row_count_next = row_count_reg + 1'b1;
                    end
                end
                else
                begin
                    plane_count_next = plane_count_reg + 1'b1;
                end
            end
            else
            begin
                col_count_next = col_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg   <= '0;
            plane_count_reg <= '0;
            row_count_reg   <= '0;
            s1_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            col_count_reg   <= col_count_next;
            plane_count_reg <= plane_count_next;
            row_count_reg   <= row_count_next;
            s1_valid_reg    <= s1_valid_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // frame store: one write port, two registered read ports
    // ------------------------------------------------------------------
    // upper pixel sits at row*width+col, lower one a half panel further down;
    // both wrap at the store size
    logic [31:0]                    up_full;
    logic [31:0]                    lo_full;
    logic [lmbs_pkg::ADDR_W-1:0]    up_addr;
    logic [lmbs_pkg::ADDR_W-1:0]    lo_addr;

    assign up_full = 32'(row_count_reg) * 32'(PANEL_WIDTH) + 32'(col_count_reg);
    assign lo_full = (32'(row_count_reg) + 32'(ROW_PAIRS)) * 32'(PANEL_WIDTH)
                     + 32'(col_count_reg);
    assign up_addr = up_full[lmbs_pkg::ADDR_W-1:0];
    assign lo_addr = lo_full[lmbs_pkg::ADDR_W-1:0];

    logic [lmbs_pkg::PIXEL_W-1:0] frame_store [lmbs_pkg::STORE_DEPTH];
    logic [lmbs_pkg::PIXEL_W-1:0] up_pixel_reg;
    logic [lmbs_pkg::PIXEL_W-1:0] lo_pixel_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            frame_store[pixel_addr] <= pixel_rgb;
        end
        if (tick)
        begin
            up_pixel_reg <= frame_store[up_addr];
            lo_pixel_reg <= frame_store[lo_addr];
        end
    end

    // ------------------------------------------------------------------
    // read stage side information, captured with the store read
    // ------------------------------------------------------------------
    logic                              s1_data_reg;
    logic                              s1_latch_reg;
    logic [lmbs_pkg::COLUMN_W-1:0]     s1_col_reg;
    logic [lmbs_pkg::ROW_OUT_W-1:0]    s1_row_reg;
    logic [lmbs_pkg::PLANE_W-1:0]      s1_plane_reg;
    logic [lmbs_pkg::ON_TIME_W-1:0]    s1_on_time_reg;
    logic                              s1_done_reg;

    logic [lmbs_pkg::ON_TIME_W-1:0]    on_time_calc;

    // base doubled once per plane, kept to the field width
    assign on_time_calc = lmbs_pkg::ON_TIME_W'(on_time_base_reg) << plane_count_reg;

    always_ff @(posedge clk)
    begin
        if (tick)
        begin
            s1_data_reg    <= step_data;
            s1_latch_reg   <= step_latch;
            s1_col_reg     <= step_latch ? '0 : lmbs_pkg::COLUMN_W'(col_count_reg);
            s1_row_reg     <= lmbs_pkg::ROW_OUT_W'(row_count_reg);
            s1_plane_reg   <= plane_count_reg;
            s1_on_time_reg <= step_latch ? on_time_calc : '0;
            s1_done_reg    <= step_latch && last_step;
        end
    end

    // ------------------------------------------------------------------
    // output register: plane bit selection, dummy and latch steps carry no pixels
    // ------------------------------------------------------------------
    logic                              is_latch_reg;
    logic [lmbs_pkg::BITS_W-1:0]       upper_bits_reg;
    logic [lmbs_pkg::BITS_W-1:0]       lower_bits_reg;
    logic [lmbs_pkg::COLUMN_W-1:0]     column_reg;
    logic [lmbs_pkg::ROW_OUT_W-1:0]    row_addr_reg;
    logic [lmbs_pkg::PLANE_W-1:0]      bit_plane_reg;
    logic [lmbs_pkg::ON_TIME_W-1:0]    on_time_reg;
    logic                              frame_done_reg;

    always_ff @(posedge clk)
    begin
        if (s2_free && s1_valid_reg)
        begin
            is_latch_reg   <= s1_latch_reg;
            upper_bits_reg <= s1_data_reg ? lmbs_pkg::plane_bits(up_pixel_reg, s1_plane_reg)
                                          : '0;
            lower_bits_reg <= s1_data_reg ? lmbs_pkg::plane_bits(lo_pixel_reg, s1_plane_reg)
                                          : '0;
            column_reg     <= s1_col_reg;
            row_addr_reg   <= s1_row_reg;
            bit_plane_reg  <= s1_plane_reg;
            on_time_reg    <= s1_on_time_reg;
            frame_done_reg <= s1_done_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign is_latch   = is_latch_reg;
    assign upper_bits = upper_bits_reg;
    assign lower_bits = lower_bits_reg;
    assign column     = column_reg;
    assign row_addr   = row_addr_reg;
    assign bit_plane  = bit_plane_reg;
    assign on_time    = on_time_reg;
    assign frame_done = frame_done_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `LMBS_ASSERT_NOW(a_latch_no_pixels, clk, rst_n, out_valid_reg && is_latch_reg,
        column_reg == '0 && upper_bits_reg == '0 && lower_bits_reg == '0,
        "latch word carries pixel or column data")
    `LMBS_ASSERT_NOW(a_data_no_timing, clk, rst_n, out_valid_reg && !is_latch_reg,
        on_time_reg == '0 && !frame_done_reg,
        "column word carries on time or frame end")
    `LMBS_ASSERT_NEXT(a_stage_moves, clk, rst_n, s1_valid_reg && s2_free,
        out_valid_reg,
        "read stage word lost on the way to the output")
    `LMBS_ASSERT_NEXT(a_write_no_word, clk, rst_n, wr_en && s1_free,
        !s1_valid_reg,
        "pixel write produced a scan word")

endmodule

`default_nettype wire
